// ----- rtl/scba_pkg.sv -----
// ----------------------------------------------------------------------------
// scba_pkg: shared types and constants of the size-class bin allocator
// Holds the item layouts, result codes, datapath commands and status, and the
// tables of the 27 size classes.
// ----------------------------------------------------------------------------
package scba_pkg;

	localparam int NUM_CLASSES   = 27;
	localparam int PAGE_BYTES    = 4096;
	localparam int SMALL_CLASSES = 11;
	localparam logic [4:0]  LAST_CLASS = 5'd26;
	localparam logic [23:0] MAX_REQ    = 24'h010000;
	localparam logic [16:0] CNT_MAX17  = 17'h1FFFF;
	localparam logic [8:0]  CNT_MAX9   = 9'h1FF;

	// result codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_TOO_BIG   = 2'd1;
	localparam logic [1:0] ST_EXHAUSTED = 2'd2;
	localparam logic [1:0] ST_UNTAGGED  = 2'd3;

	typedef struct packed {
		logic        kind;
		logic [23:0] request_size;
		logic [19:0] free_offset;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [19:0] block_offset;
		logic [4:0]  size_class;
		logic [16:0] class_live_count;
		logic [8:0]  page_elements_left;
	} rsp_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_CLEAR,
		OP_LATCH,
		OP_SEARCH,
		OP_POP_INIT,
		OP_LINK_RED,
		OP_LINK_RD,
		OP_POP,
		OP_RUN,
		OP_TAG,
		OP_CARVE,
		OP_ADJ_INIT,
		OP_ADJ_RD,
		OP_ADJ_WR,
		OP_FREE_RD,
		OP_FREE_CHK,
		OP_FREE_UPD,
		OP_ERR_BIG,
		OP_ERR_FULL,
		OP_ERR_TAG,
		OP_DONE
	} dp_op_t;

	typedef struct packed {
		logic is_free;
		logic too_big;
		logic class_fit;
		logic list_nonempty;
		logic run_empty;
		logic heap_full;
		logic pn_last;
		logic idx_ok;
		logic tag_ok;
		logic clr_last;
	} dp_stat_t;

	// element size in bytes of a class
	function automatic logic [16:0] class_size(input logic [4:0] c);
		case (c)
			5'd0:    class_size = 17'd16;
			5'd1:    class_size = 17'd32;
			5'd2:    class_size = 17'd44;
			5'd3:    class_size = 17'd64;
			5'd4:    class_size = 17'd89;
			5'd5:    class_size = 17'd128;
			5'd6:    class_size = 17'd256;
			5'd7:    class_size = 17'd315;
			5'd8:    class_size = 17'd512;
			5'd9:    class_size = 17'd1024;
			5'd10:   class_size = 17'd2048;
			default: class_size = 17'(c - 5'd10) << 12;
		endcase
	endfunction

	// elements in a fresh run, and the element count tagged on each of its pages
	function automatic logic [8:0] run_count(input logic [4:0] c);
		case (c)
			5'd0:    run_count = 9'd256;
			5'd1:    run_count = 9'd128;
			5'd2:    run_count = 9'd93;
			5'd3:    run_count = 9'd64;
			5'd4:    run_count = 9'd46;
			5'd5:    run_count = 9'd32;
			5'd6:    run_count = 9'd16;
			5'd7:    run_count = 9'd13;
			5'd8:    run_count = 9'd8;
			5'd9:    run_count = 9'd4;
			5'd10:   run_count = 9'd2;
			default: run_count = 9'd1;
		endcase
	endfunction

	// pages spanned by one block of a class
	function automatic logic [4:0] span_pages(input logic [4:0] c);
		span_pages = (c < 5'(SMALL_CLASSES)) ? 5'd1 : (c - 5'd10);
	endfunction

endpackage

// ----- rtl/size_class_bin_allocator_unit.sv -----
// ----------------------------------------------------------------------------
// size_class_bin_allocator_unit: size-class heap allocator
// Serves allocate and free items over 27 size classes with per-class LIFO
// free lists, carved runs, a bump pointer and per-page tags.
//
//  channel  | handshake              | payload
//  ---------+------------------------+--------------------------------
//  item in  | start high, busy low   | req  (kind, request_size, free_offset)
//  result   | done, one-cycle strobe | rsp  (status, offset, class, counts)
//
// An allocate is decoded, then the class search steps one class at a time
// until the class fits. The block is popped from the class free list, after
// the link index reduction and a link read, or carved from the class run, a
// fresh run first having each of its pages tagged; then the element count of
// each page of the block is stepped down. A free reads and checks the page
// tag, steps up the count of each page of the block, reduces the link index
// (never needed at the default heap) and pushes the block on the free list.
// After reset busy stays high for a clearing pass over all min(HEAP_BYTES/4096,
// 1024) entries of the page tag RAM. The result is shown for one cycle as
// busy drops; the receiver cannot stall it.
// ----------------------------------------------------------------------------
module size_class_bin_allocator_unit import scba_pkg::*; #(
	parameter int HEAP_BYTES = 1048576
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t req,
	output logic done,
	output rsp_t rsp
);

	dp_op_t   op;
	dp_stat_t st;

	scba_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.st    (st),
		.op    (op),
		.busy  (busy)
	);

	scba_dp #(
		.HEAP_BYTES(HEAP_BYTES)
	) u_dp (
		.clk   (clk),
		.arst_n(arst_n),
		.op    (op),
		.req   (req),
		.st    (st),
		.done  (done),
		.rsp   (rsp)
	);

endmodule

// ----- rtl/scba_ram.sv -----
// ----------------------------------------------------------------------------
// scba_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module scba_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write, then register the read word
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- rtl/scba_ctrl.sv -----
// ----------------------------------------------------------------------------
// scba_ctrl: allocator sequencer
// Walks each item through class search, pop or carve, page tagging, page
// count adjustment and free-list update, issuing one datapath command a cycle.
// ----------------------------------------------------------------------------
module scba_ctrl import scba_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  dp_stat_t st,
	output dp_op_t   op,
	output logic     busy
);

	typedef enum logic [4:0] {
		S_CLEAR,
		S_IDLE,
		S_DECODE,
		S_SEARCH,
		S_ALLOC,
		S_TAG,
		S_CARVE,
		S_RED,
		S_LINK_RD,
		S_POP,
		S_ADJ_INIT,
		S_ADJ_RD,
		S_ADJ_WR,
		S_FREE_RD,
		S_FREE_CHK,
		S_FREE_UPD,
		S_DONE
	} state_t;

	state_t state_q, state_nxt;
	logic   busy_q;

	assign busy = busy_q;

	// pick the next state and the command for this cycle
	always_comb begin
		state_nxt = state_q;
		op        = OP_NONE;
		case (state_q)
			S_CLEAR: begin
				op = OP_CLEAR;
				if (st.clr_last) state_nxt = S_IDLE;
			end
			S_IDLE: begin
				if (start) begin
					op        = OP_LATCH;
					state_nxt = S_DECODE;
				end
			end
			S_DECODE: begin
				if (st.is_free) begin
					state_nxt = S_FREE_RD;
				end else if (st.too_big) begin
					op        = OP_ERR_BIG;
					state_nxt = S_IDLE;
				end else begin
					state_nxt = S_SEARCH;
				end
			end
			S_SEARCH: begin
				if (st.class_fit) state_nxt = S_ALLOC;
				else op = OP_SEARCH;
			end
			S_ALLOC: begin
				if (st.list_nonempty) begin
					op        = OP_POP_INIT;
					state_nxt = S_RED;
				end else if (st.run_empty) begin
					if (st.heap_full) begin
						op        = OP_ERR_FULL;
						state_nxt = S_IDLE;
					end else begin
						op        = OP_RUN;
						state_nxt = S_TAG;
					end
				end else begin
					state_nxt = S_CARVE;
				end
			end
			S_TAG: begin
				op = OP_TAG;
				if (st.pn_last) state_nxt = S_CARVE;
			end
			S_CARVE: begin
				op        = OP_CARVE;
				state_nxt = S_ADJ_INIT;
			end
			S_RED: begin
				if (!st.idx_ok) op = OP_LINK_RED;
				else if (st.is_free) state_nxt = S_FREE_UPD;
				else state_nxt = S_LINK_RD;
			end
			S_LINK_RD: begin
				op        = OP_LINK_RD;
				state_nxt = S_POP;
			end
			S_POP: begin
				op        = OP_POP;
				state_nxt = S_ADJ_INIT;
			end
			S_ADJ_INIT: begin
				op        = OP_ADJ_INIT;
				state_nxt = S_ADJ_RD;
			end
			S_ADJ_RD: begin
				op        = OP_ADJ_RD;
				state_nxt = S_ADJ_WR;
			end
			S_ADJ_WR: begin
				op = OP_ADJ_WR;
				if (!st.pn_last) state_nxt = S_ADJ_RD;
				else if (st.is_free) state_nxt = S_RED;
				else state_nxt = S_DONE;
			end
			S_FREE_RD: begin
				op        = OP_FREE_RD;
				state_nxt = S_FREE_CHK;
			end
			S_FREE_CHK: begin
				if (!st.tag_ok) begin
					op        = OP_ERR_TAG;
					state_nxt = S_IDLE;
				end else begin
					op        = OP_FREE_CHK;
					state_nxt = S_ADJ_INIT;
				end
			end
			S_FREE_UPD: begin
				op        = OP_FREE_UPD;
				state_nxt = S_DONE;
			end
			S_DONE: begin
				op        = OP_DONE;
				state_nxt = S_IDLE;
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	// hold state; busy is high everywhere but idle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			busy_q  <= 1'b1;
		end else begin
			state_q <= state_nxt;
			busy_q  <= (state_nxt != S_IDLE);
		end
	end

endmodule

// ----- rtl/scba_dp.sv -----
// ----------------------------------------------------------------------------
// scba_dp: allocator datapath
// Per-class lists and runs, bump pointer, page tag RAM, free-link RAM and
// the result register, all stepped by the sequencer's commands.
// ----------------------------------------------------------------------------
module scba_dp import scba_pkg::*; #(
	parameter int HEAP_BYTES = 1048576
) (
	input  logic     clk,
	input  logic     arst_n,
	input  dp_op_t   op,
	input  req_t     req,
	output dp_stat_t st,
	output logic     done,
	output rsp_t     rsp
);

	localparam int PAGE_COUNT = HEAP_BYTES / PAGE_BYTES;
	localparam int TAG_DEPTH  = (PAGE_COUNT < 1024) ? PAGE_COUNT : 1024;
	localparam int TAW        = $clog2(TAG_DEPTH);
	localparam int GRANULES   = HEAP_BYTES / 16;
	localparam int LINK_DEPTH = (GRANULES < 65536) ? GRANULES : 65536;
	localparam int LAW        = $clog2(LINK_DEPTH);

	// latched item and working registers
	logic        kind_q;
	logic [23:0] size_q;
	logic [19:0] off_q;
	logic [4:0]  cls_q;
	logic [19:0] addr_q;
	logic [15:0] idx_q;
	logic [9:0]  pg_q;
	logic [4:0]  pn_q;
	logic        first_q;
	logic [8:0]  left_q;
	logic [TAW-1:0] clr_q;
	logic [20:0] bump_q;

	// per-class state
	logic [19:0] head_q  [NUM_CLASSES];
	logic [19:0] cptr_q  [NUM_CLASSES];
	logic [16:0] len_q   [NUM_CLASSES];
	logic [8:0]  cleft_q [NUM_CLASSES];
	logic [16:0] live_q  [NUM_CLASSES];

	logic        done_q;
	rsp_t        rsp_q;

	// derived values
	logic [16:0] elem;
	logic [16:0] grow;
	logic [9:0]  free_pg;
	logic        pg_in;
	logic        free_in;
	logic [15:0] tag_rd;
	logic [8:0]  cnt_old;
	logic [8:0]  cnt_new;
	logic [15:0] tag_adj;
	logic [15:0] tag_run;
	logic [4:0]  tag_cls;
	logic        tag_we;
	logic [TAW-1:0] tag_waddr;
	logic [15:0] tag_wdata;
	logic [TAW-1:0] tag_raddr;
	logic [19:0] link_rd;

	assign elem    = class_size(cls_q);
	assign grow    = (cls_q < 5'(SMALL_CLASSES)) ? 17'(PAGE_BYTES) : elem;
	assign free_pg = {2'b00, off_q[19:12]};
	assign pg_in   = {3'b000, pg_q} < 13'(PAGE_COUNT);
	assign free_in = {3'b000, free_pg} < 13'(PAGE_COUNT);

	// step one page count up on free, down on allocate, saturating
	assign cnt_old = tag_rd[13:5];
	always_comb begin
		cnt_new = cnt_old;
		if (kind_q) begin
			if (cnt_old != CNT_MAX9) cnt_new = cnt_old + 9'd1;
		end else begin
			if (cnt_old != 9'd0) cnt_new = cnt_old - 9'd1;
		end
	end
	assign tag_adj = {tag_rd[15:14], cnt_new, tag_rd[4:0]};
	assign tag_run = {1'b1, 1'b0, run_count(cls_q), cls_q};
	assign tag_cls = (tag_rd[4:0] > LAST_CLASS) ? LAST_CLASS : tag_rd[4:0];

	// status to the sequencer
	always_comb begin
		st.is_free       = kind_q;
		st.too_big       = size_q > MAX_REQ;
		st.class_fit     = {7'd0, elem} >= size_q;
		st.list_nonempty = len_q[cls_q] != 17'd0;
		st.run_empty     = cleft_q[cls_q] == 9'd0;
		st.heap_full     = (25'(bump_q) + 25'(grow)) > 25'(HEAP_BYTES);
		st.pn_last       = pn_q == 5'd1;
		st.idx_ok        = {1'b0, idx_q} < 17'(LINK_DEPTH);
		st.tag_ok        = free_in && tag_rd[15];
		st.clr_last      = clr_q == TAW'(TAG_DEPTH - 1);
	end

	// page tag store port selection
	always_comb begin
		tag_we    = 1'b0;
		tag_waddr = pg_q[TAW-1:0];
		tag_wdata = tag_adj;
		case (op)
			OP_CLEAR: begin
				tag_we    = 1'b1;
				tag_waddr = clr_q;
				tag_wdata = 16'd0;
			end
			OP_TAG: begin
				tag_we    = pg_in;
				tag_wdata = tag_run;
			end
			OP_ADJ_WR: tag_we = pg_in;
			default:   tag_we = 1'b0;
		endcase
	end
	assign tag_raddr = (op == OP_FREE_RD) ? free_pg[TAW-1:0] : pg_q[TAW-1:0];

	scba_ram #(
		.WIDTH(16),
		.DEPTH(TAG_DEPTH)
	) u_tag_ram (
		.clk  (clk),
		.we   (tag_we),
		.waddr(tag_waddr),
		.wdata(tag_wdata),
		.raddr(tag_raddr),
		.rdata(tag_rd)
	);

	scba_ram #(
		.WIDTH(20),
		.DEPTH(LINK_DEPTH)
	) u_link_ram (
		.clk  (clk),
		.we   (op == OP_FREE_UPD),
		.waddr(idx_q[LAW-1:0]),
		.wdata(head_q[cls_q]),
		.raddr(idx_q[LAW-1:0]),
		.rdata(link_rd)
	);

	// working registers and list heads, no reset needed
	always_ff @(posedge clk) begin
		case (op)
			OP_LATCH: begin
				kind_q <= req.kind;
				size_q <= req.request_size;
				off_q  <= req.free_offset;
				cls_q  <= 5'd0;
			end
			OP_SEARCH: cls_q <= cls_q + 5'd1;
			OP_POP_INIT: begin
				addr_q <= head_q[cls_q];
				idx_q  <= head_q[cls_q][19:4];
			end
			OP_LINK_RED: idx_q <= idx_q - 16'(LINK_DEPTH);
			OP_POP: head_q[cls_q] <= link_rd;
			OP_RUN: begin
				pg_q          <= {1'b0, bump_q[20:12]};
				pn_q          <= span_pages(cls_q);
				cptr_q[cls_q] <= bump_q[19:0];
			end
			OP_TAG: begin
				pg_q <= pg_q + 10'd1;
				pn_q <= pn_q - 5'd1;
			end
			OP_CARVE: begin
				addr_q        <= cptr_q[cls_q];
				cptr_q[cls_q] <= cptr_q[cls_q] + 20'(elem);
			end
			OP_ADJ_INIT: begin
				pg_q    <= {2'b00, addr_q[19:12]};
				pn_q    <= span_pages(cls_q);
				first_q <= 1'b1;
			end
			OP_ADJ_WR: begin
				if (first_q) left_q <= pg_in ? cnt_new : 9'd0;
				first_q <= 1'b0;
				pg_q    <= pg_q + 10'd1;
				pn_q    <= pn_q - 5'd1;
			end
			OP_FREE_CHK: begin
				cls_q  <= tag_cls;
				addr_q <= off_q;
				idx_q  <= off_q[19:4];
			end
			OP_FREE_UPD: head_q[cls_q] <= off_q;
			default: ;
		endcase
	end

	// counters, bump pointer and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q  <= '0;
			bump_q <= 21'd0;
			done_q <= 1'b0;
			for (int i = 0; i < NUM_CLASSES; i++) begin
				len_q[i]   <= 17'd0;
				cleft_q[i] <= 9'd0;
				live_q[i]  <= 17'd0;
			end
		end else begin
			done_q <= 1'b0;
			case (op)
				OP_CLEAR: clr_q <= clr_q + TAW'(1);
				OP_POP: len_q[cls_q] <= len_q[cls_q] - 17'd1;
				OP_RUN: begin
					cleft_q[cls_q] <= run_count(cls_q);
					bump_q         <= bump_q + 21'(grow);
				end
				OP_CARVE: cleft_q[cls_q] <= cleft_q[cls_q] - 9'd1;
				OP_ADJ_INIT: begin
					if (!kind_q && live_q[cls_q] != CNT_MAX17)
						live_q[cls_q] <= live_q[cls_q] + 17'd1;
				end
				OP_FREE_UPD: begin
					if (len_q[cls_q] != CNT_MAX17) len_q[cls_q] <= len_q[cls_q] + 17'd1;
					if (live_q[cls_q] != 17'd0) live_q[cls_q] <= live_q[cls_q] - 17'd1;
				end
				OP_ERR_BIG, OP_ERR_FULL, OP_ERR_TAG, OP_DONE: done_q <= 1'b1;
				default: ;
			endcase
		end
	end

	// result word
	always_ff @(posedge clk) begin
		case (op)
			OP_ERR_BIG: rsp_q <= '{ST_TOO_BIG, 20'd0, 5'd0, 17'd0, 9'd0};
			OP_ERR_TAG: rsp_q <= '{ST_UNTAGGED, 20'd0, 5'd0, 17'd0, 9'd0};
			OP_ERR_FULL: rsp_q <= '{ST_EXHAUSTED, 20'd0, cls_q, live_q[cls_q], 9'd0};
			OP_DONE: rsp_q <= '{ST_OK, kind_q ? 20'd0 : addr_q, cls_q, live_q[cls_q], left_q};
			default: ;
		endcase
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

// ----- rtl/scba_checker.sv -----
// ----------------------------------------------------------------------------
// scba_checker: port-level checks of the allocator
// Watches the item and result ports and flags sequencing slips.
// ----------------------------------------------------------------------------
module scba_checker import scba_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input rsp_t rsp
);

	// an accepted item keeps the unit busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("unit not busy after accepting an item");

	// a result comes as the unit goes idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while busy");

	// a result is a single-cycle strobe
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	// errors carry no offset and no page count
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.status != ST_OK |-> rsp.block_offset == 20'd0 &&
			rsp.page_elements_left == 9'd0)
		else $error("error result with offset or page count");

	// class always in range
	a_class_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> rsp.size_class <= LAST_CLASS)
		else $error("size class out of range");

endmodule

bind size_class_bin_allocator_unit scba_checker u_scba_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.busy  (busy),
	.done  (done),
	.rsp   (rsp)
);

// ----- tb/size_class_bin_allocator_unit_tb.sv -----
// ----------------------------------------------------------------------------
// size_class_bin_allocator_unit_tb: self-checking bench of the bin allocator
// Runs directed and random allocate and free items through the unit. The
// outcome of each item is worked out ahead by a behavioural model of the
// allocator and compared field by field with every result strobe.
// ----------------------------------------------------------------------------
module size_class_bin_allocator_unit_tb import scba_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int HEAP       = 1048576;
	localparam int PAGES      = HEAP / 4096;
	localparam int N_RANDOM   = 1000;
	localparam int STALL_MAX  = 20000;
	localparam logic KIND_ALLOC = 1'b0;
	localparam logic KIND_FREE  = 1'b1;

	typedef struct {
		req_t rq;
		rsp_t rs;
		bit   drain;
		int   idle_pct;
	} item_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	req_t req;
	logic done;
	rsp_t rsp;

	size_class_bin_allocator_unit u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req(req), .done(done), .rsp(rsp)
	);

	// model state of the heap
	int unsigned m_bump;
	logic [19:0] m_head [NUM_CLASSES];
	int unsigned m_len  [NUM_CLASSES];
	logic [19:0] m_carve[NUM_CLASSES];
	int unsigned m_left [NUM_CLASSES];
	int unsigned m_live [NUM_CLASSES];
	logic [15:0] m_tag  [PAGES];
	logic [19:0] m_link [HEAP / 16];

	item_t  pending[$];
	rsp_t   awaited[$];
	logic [19:0] held_blocks[$];
	int     n_sent, n_taken, n_errors, n_results, stall_cnt;
	int     n_exhausted, n_untagged, n_too_big;

	function automatic int unsigned elem_bytes(input int c);
		int unsigned tbl[11] = '{16, 32, 44, 64, 89, 128, 256, 315, 512, 1024, 2048};
		if (c < 11)
			return tbl[c];
		return (c - 10) * 4096;
	endfunction

	function automatic int unsigned page_free(input int unsigned p);
		return (p < PAGES) ? 32'(m_tag[p][13:5]) : 0;
	endfunction

	// step the element count of every page a block covers
	function automatic void shift_pages(input int unsigned off, input int unsigned el,
			input bit up);
		int unsigned first, n, p, cnt;
		first = off / 4096;
		n = (el < 4096) ? 1 : el / 4096;
		for (int i = 0; i < n; i++) begin
			p = first + i;
			cnt = page_free(p);
			if (up) begin
				if (cnt < 511) cnt++;
			end else if (cnt > 0) begin
				cnt--;
			end
			if (p < PAGES)
				m_tag[p][13:5] = 9'(cnt);
		end
	endfunction

	function automatic rsp_t mk_rsp(input logic [1:0] st, input int unsigned blk,
			input int unsigned c, input int unsigned live, input int unsigned left);
		rsp_t r;
		r.status = st;
		r.block_offset = 20'(blk);
		r.size_class = 5'(c);
		r.class_live_count = 17'(live);
		r.page_elements_left = 9'(left);
		return r;
	endfunction

	// work out the outcome of one item and advance the heap model
	function automatic rsp_t heap_outcome(input req_t r);
		int unsigned c, el, addr, grow, cnt, off, p;
		if (r.kind == KIND_ALLOC) begin
			if (r.request_size > 24'h010000)
				return mk_rsp(ST_TOO_BIG, 0, 0, 0, 0);
			c = 0;
			while (c < NUM_CLASSES - 1 && r.request_size > elem_bytes(c))
				c++;
			el = elem_bytes(c);
			if (m_len[c] != 0) begin
				addr = m_head[c];
				m_head[c] = m_link[addr >> 4];
				m_len[c]--;
			end else begin
				if (m_left[c] == 0) begin
					grow = (el < 4096) ? 4096 : el;
					if (m_bump + grow > HEAP)
						return mk_rsp(ST_EXHAUSTED, 0, c, m_live[c], 0);
					cnt = (el < 4096) ? 4096 / el : 1;
					for (int unsigned a = m_bump; a < m_bump + grow; a += 4096)
						m_tag[a / 4096] = {1'b1, 1'b0, 9'(cnt), 5'(c)};
					m_carve[c] = 20'(m_bump);
					m_left[c] = grow / el;
					m_bump += grow;
				end
				m_left[c]--;
				addr = m_carve[c];
				m_carve[c] = 20'(m_carve[c] + el);
			end
			if (m_live[c] < 131071) m_live[c]++;
			shift_pages(addr, el, 1'b0);
			return mk_rsp(ST_OK, addr, c, m_live[c], page_free(addr / 4096));
		end
		off = r.free_offset;
		p = off / 4096;
		if (p >= PAGES || !m_tag[p][15])
			return mk_rsp(ST_UNTAGGED, 0, 0, 0, 0);
		c = m_tag[p][4:0];
		if (c >= NUM_CLASSES) c = NUM_CLASSES - 1;
		el = elem_bytes(c);
		shift_pages(off, el, 1'b1);
		m_link[off >> 4] = m_head[c];
		m_head[c] = 20'(off);
		if (m_len[c] < 131071) m_len[c]++;
		if (m_live[c] > 0) m_live[c]--;
		return mk_rsp(ST_OK, 0, c, m_live[c], page_free(p));
	endfunction

	// queue one item with its outcome
	task automatic add_item(input logic kind, input logic [23:0] sz, input logic [19:0] off,
			input int idle_pct, input bit drain);
		item_t it;
		it.rq.kind = kind;
		it.rq.request_size = sz;
		it.rq.free_offset = off;
		it.rs = heap_outcome(it.rq);
		it.drain = drain;
		it.idle_pct = idle_pct;
		if (kind == KIND_ALLOC && it.rs.status == ST_OK)
			held_blocks.push_back(it.rs.block_offset);
		if (it.rs.status == ST_EXHAUSTED) n_exhausted++;
		if (it.rs.status == ST_UNTAGGED) n_untagged++;
		if (it.rs.status == ST_TOO_BIG) n_too_big++;
		pending.push_back(it);
	endtask

	// clock
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// driver: raise start at the falling edge, hold it until the item is taken
	always @(negedge clk) begin
		if (arst_n && !(start && n_taken != n_sent)) begin
			if (pending.size() != 0 && !(pending[0].drain && awaited.size() != 0)
					&& $urandom_range(99) >= pending[0].idle_pct) begin
				req <= pending[0].rq;
				start <= 1'b1;
				awaited.push_back(pending[0].rs);
				pending.pop_front();
				n_sent++;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor: check each result strobe, count accepted items, watch for a hang
	always @(posedge clk) begin
		if (arst_n) begin
			if (done) begin
				if (awaited.size() == 0) begin
					$error("result with no item outstanding");
					n_errors++;
				end else begin
					if (rsp.status !== awaited[0].status) begin
						$error("status: expected %0d, got %0d", awaited[0].status, rsp.status);
						n_errors++;
					end
					if (rsp.block_offset !== awaited[0].block_offset) begin
						$error("block_offset: expected %h, got %h",
							awaited[0].block_offset, rsp.block_offset);
						n_errors++;
					end
					if (rsp.size_class !== awaited[0].size_class) begin
						$error("size_class: expected %0d, got %0d",
							awaited[0].size_class, rsp.size_class);
						n_errors++;
					end
					if (rsp.class_live_count !== awaited[0].class_live_count) begin
						$error("class_live_count: expected %0d, got %0d",
							awaited[0].class_live_count, rsp.class_live_count);
						n_errors++;
					end
					if (rsp.page_elements_left !== awaited[0].page_elements_left) begin
						$error("page_elements_left: expected %0d, got %0d",
							awaited[0].page_elements_left, rsp.page_elements_left);
						n_errors++;
					end
					awaited.pop_front();
				end
				n_results++;
			end
			if (start && !busy)
				n_taken++;
			if (done || (start && !busy) || awaited.size() == 0 && pending.size() == 0)
				stall_cnt <= 0;
			else
				stall_cnt <= stall_cnt + 1;
			if (stall_cnt >= STALL_MAX) begin
				$display("watchdog: no progress in %0d cycles", STALL_MAX);
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	initial begin
		int phase, idle, pick, mode;
		logic [23:0] sz;
		logic [19:0] off;
		start = 1'b0;
		req = '0;
		arst_n = 1'b0;
		n_sent = 0; n_taken = 0; n_errors = 0; n_results = 0; stall_cnt = 0;
		n_exhausted = 0; n_untagged = 0; n_too_big = 0;
		m_bump = 0;
		for (int c = 0; c < NUM_CLASSES; c++) begin
			m_head[c] = '0; m_len[c] = 0; m_carve[c] = '0; m_left[c] = 0; m_live[c] = 0;
		end
		for (int p = 0; p < PAGES; p++) m_tag[p] = '0;

		// directed: class edges, too-large sizes, untagged and odd frees
		add_item(KIND_ALLOC, 24'd0, 20'hFFFFF, 0, 0);
		add_item(KIND_ALLOC, 24'd16, 20'd0, 0, 0);
		add_item(KIND_ALLOC, 24'd17, 20'd0, 0, 0);
		add_item(KIND_ALLOC, 24'd44, 20'd0, 0, 0);
		add_item(KIND_ALLOC, 24'd45, 20'd0, 0, 0);
		add_item(KIND_ALLOC, 24'd315, 20'd0, 0, 0);
		add_item(KIND_ALLOC, 24'd2049, 20'd0, 0, 0);
		add_item(KIND_ALLOC, 24'd4096, 20'd0, 0, 0);
		add_item(KIND_ALLOC, 24'd65536, 20'd0, 0, 0);
		add_item(KIND_ALLOC, 24'd65537, 20'd0, 0, 0);
		add_item(KIND_ALLOC, 24'hFFFFFF, 20'hFFFFF, 0, 0);
		add_item(KIND_FREE, 24'hFFFFFF, 20'hFFFFF, 0, 0);
		add_item(KIND_FREE, 24'd0, 20'd0, 0, 0);
		add_item(KIND_ALLOC, 24'd1, 20'd0, 0, 0);
		add_item(KIND_FREE, 24'd0, held_blocks[1], 0, 0);
		add_item(KIND_FREE, 24'd0, held_blocks[1], 0, 0);
		add_item(KIND_FREE, 24'd0, held_blocks[7] + 20'd3, 0, 0);
		add_item(KIND_FREE, 24'd0, held_blocks[8] + 20'h1008, 0, 0);
		add_item(KIND_ALLOC, 24'd30, 20'd0, 0, 0);
		add_item(KIND_ALLOC, 24'd32, 20'd0, 0, 0);
		add_item(KIND_ALLOC, 24'd60000, 20'd0, 0, 1);

		// random: mostly allocate and free pairs, with noise mixed in
		for (int i = 0; i < N_RANDOM; i++) begin
			phase = i * 4 / N_RANDOM;
			idle = (phase == 0) ? 0 : (phase == 1) ? 56 : (phase == 2) ? 0 : 30;
			mode = $urandom_range(99);
			if (mode < 48 || held_blocks.size() == 0) begin
				pick = $urandom_range(99);
				if (pick < 70) sz = 24'($urandom_range(2048));
				else if (pick < 93) sz = 24'($urandom_range(65536));
				else sz = 24'($urandom);
				add_item(KIND_ALLOC, sz, 20'($urandom), idle, i % 250 == 249);
			end else if (mode < 88) begin
				pick = $urandom_range(held_blocks.size() - 1);
				off = held_blocks[pick];
				held_blocks.delete(pick);
				add_item(KIND_FREE, 24'($urandom), off, idle, i % 250 == 249);
			end else if (mode < 95) begin
				add_item(KIND_FREE, 24'($urandom), 20'($urandom), idle, 0);
			end else begin
				off = held_blocks[$urandom_range(held_blocks.size() - 1)];
				add_item(KIND_FREE, 24'($urandom), off ^ 20'($urandom_range(15)), idle, 0);
			end
		end

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		wait (pending.size() == 0 && n_taken == n_sent && awaited.size() == 0);
		repeat (200) @(posedge clk);
		$display("Covered %0d items and %0d results: %0d too large, %0d heap full, %0d untagged.",
			n_sent, n_results, n_too_big, n_exhausted, n_untagged);
		if (n_errors == 0 && awaited.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/scba_pkg.sv
rtl/scba_ram.sv
rtl/scba_ctrl.sv
rtl/scba_dp.sv
rtl/size_class_bin_allocator_unit.sv
rtl/scba_checker.sv
tb/size_class_bin_allocator_unit_tb.sv
